// ===== design/psc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID step package
// Shared types, codes and fixed widths of the PID step with clamps.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Fixed field widths.
  localparam int unsigned WordW   = 32;  // gains, clamps, setpoint, drive
  localparam int unsigned StepW   = 31;  // step_time
  localparam int unsigned ErrW    = 33;  // setpoint - measured
  localparam int unsigned DiffW   = 34;  // error - last error
  localparam int unsigned SatW    = 48;  // saturated products and integral
  localparam int unsigned SumW    = 50;  // sum of three terms
  localparam int unsigned CfgIdxW = 3;

  // Saturation limits of the 48-bit range, as magnitudes.
  localparam logic [SatW-1:0] SatLimPos = 48'h7FFF_FFFF_FFFF;
  localparam logic [SatW-1:0] SatLimNeg = 48'h8000_0000_0000;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL_GO,
    S_MUL_WAIT,
    S_MUL_POST,
    S_DIV_WAIT,
    S_SUM,
    S_OUT
  } state_e;

  // Products run through the shared multiplier, in order.
  typedef enum logic [1:0] {
    OP_INT,  // error * dt into the integral
    OP_P,    // proportional term
    OP_I,    // integral term
    OP_D     // derivative term
  } mop_e;

  // Clamp status of a result.
  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_MAX  = 2'd1,
    CLAMP_MIN  = 2'd2
  } clamp_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_STEP_TIME = 3'd3,
    REG_OUT_MAX   = 3'd4,
    REG_OUT_MIN   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [WordW-1:0] gain_p;
    logic signed [WordW-1:0] gain_i;
    logic signed [WordW-1:0] gain_d;
    logic        [StepW-1:0] step_time;
    logic signed [WordW-1:0] out_max;
    logic signed [WordW-1:0] out_min;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic mul_start;
    logic post;
    mop_e op;
    logic sum;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/psc_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID step shared multiplier
// Sign-magnitude fixed-point multiply, 33 x 48 bits, one 16-bit slice of the
// second operand per cycle, then floor rounding, shift and 48-bit saturation.
// ----------------------------------------------------------------------------
module psc_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [psc_pkg::ErrW-1:0]          a_i,
  input  logic [psc_pkg::SatW-1:0]          b_i,
  input  logic                              neg_i,
  output logic                              done_o,
  output logic signed [psc_pkg::SatW-1:0]   res_o
);
  import psc_pkg::*;

  localparam int unsigned SliceW = 16;
  localparam int unsigned Slices = SatW / SliceW;
  localparam int unsigned CntW   = $clog2(Slices);
  localparam int unsigned AccW   = ErrW + SatW;
  localparam int unsigned ShW    = AccW + 1 - FRAC_BITS;
  localparam logic [AccW:0] RndAdd = {{(AccW + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  logic [ErrW-1:0]        a_q;
  logic [SatW-1:0]        b_q;
  logic                   neg_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, fin_q, done_q;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [SliceW-1:0]      slice;
  logic [ErrW+SliceW-1:0] pp;
  logic [AccW:0]          rnd_sum;
  logic [ShW-1:0]         shifted;
  logic [SatW-1:0]        lim, mag;
  logic                   over;
  logic signed [SatW-1:0] res_q, res_d;

  // Slice product accumulates most significant slice first.
  assign slice = b_q[SliceW*cnt_q +: SliceW];
  assign pp    = a_q * slice;
  assign acc_d = {acc_q[AccW-SliceW-1:0], {SliceW{1'b0}}} + AccW'(pp);

  // Round toward minus infinity, drop fraction bits, saturate the magnitude.
  always_comb begin
    rnd_sum = {1'b0, acc_q} + ((neg_q && (acc_q != '0)) ? RndAdd : '0);
    shifted = rnd_sum[AccW:FRAC_BITS];
    lim     = neg_q ? SatLimNeg : SatLimPos;
    over    = (|shifted[ShW-1:SatW]) || (shifted[SatW-1:0] > lim);
    mag     = over ? lim : shifted[SatW-1:0];
    res_d   = neg_q ? $signed(-mag) : $signed(mag);
  end

  // Sequencing of slices and the final stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Slices - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Operands, accumulator and result.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      neg_q <= neg_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== design/psc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID step serial divider
// Restoring division of (difference << FRAC_BITS) by the time step, two
// quotient bits per cycle, with the quotient saturated to the 48-bit range.
// ----------------------------------------------------------------------------
module psc_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [psc_pkg::DiffW-1:0]   num_i,
  input  logic [psc_pkg::StepW-1:0]   den_i,
  input  logic                        neg_i,
  output logic                        done_o,
  output logic [psc_pkg::SatW-1:0]    mag_o
);
  import psc_pkg::*;

  localparam int unsigned NumW  = DiffW + FRAC_BITS;
  localparam int unsigned DivW  = NumW + (NumW % 2);
  localparam int unsigned Steps = DivW / 2;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [DivW-1:0]  quo_q;
  logic [StepW-1:0] rem_q, den_q;
  logic             neg_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [StepW:0]   t1, t2;
  logic             ge1, ge2;
  logic [StepW-1:0] r1, r2;
  logic [SatW-1:0]  lim;
  logic             over;

  // Two restoring steps per cycle; the dividend shifts out as quotient bits shift in.
  always_comb begin
    t1  = {rem_q, quo_q[DivW-1]};
    ge1 = t1 >= {1'b0, den_q};
    r1  = ge1 ? StepW'(t1 - {1'b0, den_q}) : t1[StepW-1:0];
    t2  = {r1, quo_q[DivW-2]};
    ge2 = t2 >= {1'b0, den_q};
    r2  = ge2 ? StepW'(t2 - {1'b0, den_q}) : t2[StepW-1:0];
  end

  // Saturate the quotient magnitude to what the signed 48-bit range allows.
  always_comb begin
    lim   = neg_q ? SatLimNeg : SatLimPos;
    over  = (|quo_q[DivW-1:SatW]) || (quo_q[SatW-1:0] > lim);
    mag_o = over ? lim : quo_q[SatW-1:0];
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(Steps);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Dividend, quotient and remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= DivW'({num_i, {FRAC_BITS{1'b0}}});
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-3:0], ge1, ge2};
      rem_q <= r2;
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== design/psc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID step datapath
// Error, integral and previous-error state, operand selection for the shared
// multiplier, the derivative divider, the I clamp, the sum and output clamp.
// ----------------------------------------------------------------------------
module psc_dpath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  psc_pkg::cfg_t                       cfg_i,
  input  logic signed [psc_pkg::WordW-1:0]    setpoint_i,
  input  logic signed [psc_pkg::WordW-1:0]    measured_i,
  input  logic                                clear_integral_i,
  input  psc_pkg::cmd_t                       cmd_i,
  output psc_pkg::sts_t                       sts_o,
  output logic signed [psc_pkg::WordW-1:0]    drive_o,
  output psc_pkg::clamp_e                     clamp_state_o
);
  import psc_pkg::*;

  localparam logic signed [SatW-1:0] IClampMax = SatW'(5) << FRAC_BITS;

  logic signed [ErrW-1:0]  err_q, last_err_q;
  logic signed [SatW-1:0]  integ_q, pterm_q, iterm_q, dterm_q;
  logic                    dneg_q;
  logic signed [WordW-1:0] drive_q;
  clamp_e                  clamp_q;

  logic [StepW-1:0]        dt_eff;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        diff_mag;
  logic [ErrW-1:0]         err_mag;
  logic [WordW-1:0]        gp_mag, gi_mag, gd_mag;
  logic [SatW-1:0]         integ_mag, dq_mag;
  logic [ErrW-1:0]         mul_a;
  logic [SatW-1:0]         mul_b;
  logic                    mul_neg, mul_done, div_done;
  logic signed [SatW-1:0]  mres;
  logic signed [SatW:0]    isum;
  logic signed [SatW-1:0]  isat;
  logic signed [SumW-1:0]  sum, smax, smin;
  logic signed [WordW-1:0] drive_d;
  clamp_e                  clamp_d;

  // A zero time step acts as one LSB.
  assign dt_eff = (cfg_i.step_time == '0) ? StepW'(1) : cfg_i.step_time;

  // Signed values to magnitudes.
  always_comb begin
    diff      = DiffW'(err_q) - DiffW'(last_err_q);
    diff_mag  = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    err_mag   = err_q[ErrW-1] ? ErrW'(-err_q) : ErrW'(err_q);
    gp_mag    = cfg_i.gain_p[WordW-1] ? WordW'(-cfg_i.gain_p) : WordW'(cfg_i.gain_p);
    gi_mag    = cfg_i.gain_i[WordW-1] ? WordW'(-cfg_i.gain_i) : WordW'(cfg_i.gain_i);
    gd_mag    = cfg_i.gain_d[WordW-1] ? WordW'(-cfg_i.gain_d) : WordW'(cfg_i.gain_d);
    integ_mag = integ_q[SatW-1] ? SatW'(-integ_q) : SatW'(integ_q);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd_i.op)
      OP_INT: begin
        mul_a   = err_mag;
        mul_b   = SatW'(dt_eff);
        mul_neg = err_q[ErrW-1];
      end
      OP_P: begin
        mul_a   = ErrW'(gp_mag);
        mul_b   = SatW'(err_mag);
        mul_neg = cfg_i.gain_p[WordW-1] ^ err_q[ErrW-1];
      end
      OP_I: begin
        mul_a   = ErrW'(gi_mag);
        mul_b   = integ_mag;
        mul_neg = cfg_i.gain_i[WordW-1] ^ integ_q[SatW-1];
      end
      OP_D: begin
        mul_a   = ErrW'(gd_mag);
        mul_b   = dq_mag;
        mul_neg = cfg_i.gain_d[WordW-1] ^ dneg_q;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  psc_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .neg_i  (mul_neg),
    .done_o (mul_done),
    .res_o  (mres)
  );

  psc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.prep),
    .num_i  (diff_mag),
    .den_i  (dt_eff),
    .neg_i  (diff[DiffW-1]),
    .done_o (div_done),
    .mag_o  (dq_mag)
  );

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;

  // Saturating integral update.
  always_comb begin
    isum = (SatW+1)'(integ_q) + (SatW+1)'(mres);
    if (isum[SatW] != isum[SatW-1]) begin
      isat = isum[SatW] ? $signed(SatLimNeg) : $signed(SatLimPos);
    end else begin
      isat = isum[SatW-1:0];
    end
  end

  // Sum of terms and output clamp; the upper bound is tested first.
  always_comb begin
    sum  = SumW'(pterm_q) + SumW'(iterm_q) + SumW'(dterm_q);
    smax = SumW'($signed(cfg_i.out_max));
    smin = SumW'($signed(cfg_i.out_min));
    if (sum > smax) begin
      drive_d = cfg_i.out_max;
      clamp_d = CLAMP_MAX;
    end else if (sum < smin) begin
      drive_d = cfg_i.out_min;
      clamp_d = CLAMP_MIN;
    end else begin
      drive_d = sum[WordW-1:0];
      clamp_d = CLAMP_NONE;
    end
  end

  // Controller state carried between items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else begin
      if (cmd_i.capture && clear_integral_i) begin
        integ_q <= '0;
      end else if (cmd_i.post && (cmd_i.op == OP_INT)) begin
        integ_q <= isat;
      end
      if (cmd_i.prep) begin
        last_err_q <= err_q;
      end
    end
  end

  // Working registers of one step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      err_q <= ErrW'(setpoint_i) - ErrW'(measured_i);
    end
    if (cmd_i.prep) begin
      dneg_q <= diff[DiffW-1];
    end
    if (cmd_i.post) begin
      case (cmd_i.op)
        OP_P:    pterm_q <= mres;
        OP_I:    iterm_q <= (mres > IClampMax) ? IClampMax : mres;
        OP_D:    dterm_q <= mres;
        default: ;
      endcase
    end
    if (cmd_i.sum) begin
      drive_q <= drive_d;
      clamp_q <= clamp_d;
    end
  end

  assign drive_o       = drive_q;
  assign clamp_state_o = clamp_q;

endmodule
`default_nettype wire

// ===== design/psc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID step controller
// Sequences one step: capture, divider start, the four products on the
// shared multiplier, the sum and the hand-off to the output register.
// ----------------------------------------------------------------------------
module psc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  input  psc_pkg::sts_t  sts_i,
  output psc_pkg::cmd_t  cmd_o
);
  import psc_pkg::*;

  state_e state_q, state_d;
  mop_e   op_q, op_d;

  // Next state and product index.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        op_d    = OP_INT;
        state_d = S_MUL_GO;
      end
      S_MUL_GO: begin
        state_d = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          state_d = S_MUL_POST;
        end
      end
      S_MUL_POST: begin
        unique case (op_q)
          OP_INT: begin
            op_d    = OP_P;
            state_d = S_MUL_GO;
          end
          OP_P: begin
            op_d    = OP_I;
            state_d = S_MUL_GO;
          end
          OP_I: begin
            op_d    = OP_D;
            state_d = S_DIV_WAIT;
          end
          default: begin
            state_d = S_SUM;
          end
        endcase
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_MUL_GO;
        end
      end
      S_SUM: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands decoded from the state.
  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_PREP:     cmd_o.prep      = 1'b1;
      S_MUL_GO:   cmd_o.mul_start = 1'b1;
      S_MUL_POST: cmd_o.post      = 1'b1;
      S_SUM:      cmd_o.sum       = 1'b1;
      S_OUT:      cmd_o.load_out  = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/pid_step_with_clamps.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID step with clamps
// One PID step per input beat: s_axis carries setpoint and measurement in
// tdata and the clear-integral flag in tuser; m_axis returns the clamped drive
// in tdata and the clamp status in tuser. Registers are written through the
// cfg channel (index, data), which is always ready; write them only while the
// block is idle.
// The block works on one item at a time. The serial divider for the
// derivative term, which yields two quotient bits per cycle, starts with
// the step, and the derivative product on the shared multiplier (three
// 16-bit slices) must wait for its quotient. The next input beat is taken
// once the result has moved into the output register, so a stalled
// receiver holds at most one result there; a second finished result then
// waits in the block, and the block takes no new input beat until that
// second result has moved into the output register as well.
// Reset clears the integral and the previous error, loads the register
// defaults (unity P gain, unit time step, full-range clamps) and empties the
// output register.
// ----------------------------------------------------------------------------
module pid_step_with_clamps #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [2*psc_pkg::WordW-1:0]    s_axis_tdata,   // setpoint, measured
  input  logic                           s_axis_tuser,   // clear_integral
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [psc_pkg::WordW-1:0]      m_axis_tdata,   // drive
  output logic [1:0]                     m_axis_tuser,   // clamp_state
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [psc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [psc_pkg::WordW-1:0]      cfg_data_i
);
  import psc_pkg::*;

  cfg_t                    cfg_q;
  cmd_t                    cmd;
  sts_t                    sts;
  logic                    out_free;
  logic signed [WordW-1:0] drive;
  clamp_e                  clamp_state;
  logic                    m_valid_q;
  logic [WordW-1:0]        m_data_q;
  logic [1:0]              m_user_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= WordW'(1) << FRAC_BITS;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
      cfg_q.step_time <= StepW'(1) << FRAC_BITS;
      cfg_q.out_max   <= {1'b0, {(WordW-1){1'b1}}};
      cfg_q.out_min   <= {1'b1, {(WordW-1){1'b0}}};
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_GAIN_P:    cfg_q.gain_p    <= cfg_data_i;
        REG_GAIN_I:    cfg_q.gain_i    <= cfg_data_i;
        REG_GAIN_D:    cfg_q.gain_d    <= cfg_data_i;
        REG_STEP_TIME: cfg_q.step_time <= cfg_data_i[StepW-1:0];
        REG_OUT_MAX:   cfg_q.out_max   <= cfg_data_i;
        REG_OUT_MIN:   cfg_q.out_min   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psc_dpath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .setpoint_i       (s_axis_tdata[WordW-1:0]),
    .measured_i       (s_axis_tdata[2*WordW-1:WordW]),
    .clear_integral_i (s_axis_tuser),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .drive_o          (drive),
    .clamp_state_o    (clamp_state)
  );

  // Output register; it takes a new result when empty or being drained.
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load_out) begin
      m_data_q <= drive;
      m_user_q <= clamp_state;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

// ===== tb/tb_pid_step_with_clamps.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID step with clamps testbench
// Drives PID steps through the input stream and checks every drive beat
// against a cycle-free predictor of the controller that keeps its own gains,
// clamps, integral and previous error. Directed steps cover the field
// extremes, the clamp of the I term, the zero time step, crossed output
// clamps and the saturating arithmetic. Random phases then follow, each with
// fresh register settings and its own mix of random idling on the two streams.
// ----------------------------------------------------------------------------
module tb_pid_step_with_clamps;
  import psc_pkg::*;

  localparam int unsigned FracBits    = 16;
  localparam int          ClkHalf     = 10;
  localparam int          MaxReports  = 10;
  localparam int          DrainCycles = 60;

  localparam longint SatHi    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SatLo    = -SatHi - 1;
  localparam longint DivCap   = 64'sd1 <<< 47;
  localparam longint ITermCap = 64'sd5 <<< FracBits;

  localparam logic [31:0] QOne    = 32'h0001_0000;
  localparam logic [31:0] WordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] WordMin = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] drive;
    logic [1:0]  clamp;
  } drive_result_t;

  typedef struct {
    longint gain_p;
    longint gain_i;
    longint gain_d;
    longint step_time;
    longint out_max;
    longint out_min;
  } pid_cfg_t;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [63:0] s_data    = '0;
  logic        s_clear   = 1'b0;
  logic        m_ready   = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;
  wire  [1:0]  m_user;
  wire         cfg_ready;

  // Idling controls and bookkeeping.
  logic        tx_idle_en = 1'b0;
  logic        rx_idle_en = 1'b0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;

  // Predictor state and pending drive beats.
  pid_cfg_t      shadow_cfg;
  longint        shadow_integral;
  longint        shadow_last_err;
  drive_result_t drive_expected_q[$];

  pid_step_with_clamps #(
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_clear),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #ClkHalf clk = ~clk;
  end

  // Hard limit on the run, well above the slowest legal run.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Saturate a wide signed value to the 48-bit range.
  function automatic longint clip48(input logic signed [127:0] v);
    logic [127:0] bits;
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    bits = v;
    return bits[63:0];
  endfunction

  // Fixed-point product, floored, then saturated.
  function automatic longint mul_q(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa   = a;
    wb   = b;
    prod = (wa * wb) >>> FracBits;
    return clip48(prod);
  endfunction

  // One controller step: updates the integral and previous error.
  function automatic drive_result_t predict_pid_step(input logic [31:0] sp_w,
                                                     input logic [31:0] ms_w,
                                                     input logic        clear);
    drive_result_t res;
    longint sp;
    longint ms;
    longint dt;
    longint err;
    longint p_term;
    longint i_term;
    longint d_term;
    longint diff;
    longint diff_mag;
    longint quot;
    longint total;
    sp  = $signed(sp_w);
    ms  = $signed(ms_w);
    dt  = (shadow_cfg.step_time == 0) ? 64'sd1 : shadow_cfg.step_time;
    err = sp - ms;
    if (clear) shadow_integral = 0;

    p_term          = mul_q(shadow_cfg.gain_p, err);
    shadow_integral = clip48(shadow_integral + mul_q(err, dt));
    i_term          = mul_q(shadow_cfg.gain_i, shadow_integral);
    if (i_term > ITermCap) i_term = ITermCap;

    // Derivative: truncating divide of the scaled difference by dt.
    diff     = err - shadow_last_err;
    diff_mag = (diff < 0) ? -diff : diff;
    quot     = (diff_mag <<< FracBits) / dt;
    if (quot > DivCap) quot = DivCap;
    d_term = clip48((diff < 0) ? -quot : quot);
    d_term = mul_q(shadow_cfg.gain_d, d_term);

    // Upper clamp is tested first, so crossed clamps favor out_max.
    total = p_term + i_term + d_term;
    if (total > shadow_cfg.out_max) begin
      res.drive = shadow_cfg.out_max[31:0];
      res.clamp = CLAMP_MAX;
    end else if (total < shadow_cfg.out_min) begin
      res.drive = shadow_cfg.out_min[31:0];
      res.clamp = CLAMP_MIN;
    end else begin
      res.drive = total[31:0];
      res.clamp = CLAMP_NONE;
    end
    shadow_last_err = err;
    return res;
  endfunction

  function automatic void reset_shadow();
    shadow_cfg.gain_p    = 64'sd65536;
    shadow_cfg.gain_i    = 0;
    shadow_cfg.gain_d    = 0;
    shadow_cfg.step_time = 64'sd65536;
    shadow_cfg.out_max   = 64'sd2147483647;
    shadow_cfg.out_min   = -(64'sd1 <<< 31);
    shadow_integral      = 0;
    shadow_last_err      = 0;
  endfunction

  // ------------------------------------------------------------------------
  // Output side: random stalls and the result check
  // ------------------------------------------------------------------------

  // Receiver stalls, while rx_idle_en is set, come in bursts of random length.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready    <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      m_ready    <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      m_ready    <= 1'b0;
      stall_left <= $urandom_range(1, 10);
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxReports) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Each accepted drive beat is compared with the oldest expectation.
  always @(posedge clk) begin : check_drive
    drive_result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (drive_expected_q.size() == 0) begin
        report_mismatch($sformatf("drive beat %h clamp %0d with none pending",
                                  m_data, m_user));
      end else begin
        want = drive_expected_q.pop_front();
        if (m_data !== want.drive || m_user !== want.clamp) begin
          report_mismatch($sformatf("expected drive %h clamp %0d, got drive %h clamp %0d",
                                    want.drive, want.clamp, m_data, m_user));
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------

  // Send one step; valid stays high afterwards so beats can follow back to back.
  task automatic send_step(input logic [31:0] sp, input logic [31:0] ms,
                           input logic clear);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {ms, sp};
    s_clear <= clear;
    do @(posedge clk); while (!s_ready);
    drive_expected_q = {drive_expected_q, predict_pid_step(sp, ms, clear)};
  endtask

  // Stop sending and wait until every pending drive beat has arrived.
  task automatic quiesce();
    s_valid <= 1'b0;
    while (drive_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_P:    shadow_cfg.gain_p    = $signed(value);
      REG_GAIN_I:    shadow_cfg.gain_i    = $signed(value);
      REG_GAIN_D:    shadow_cfg.gain_d    = $signed(value);
      REG_STEP_TIME: shadow_cfg.step_time = value[30:0];
      REG_OUT_MAX:   shadow_cfg.out_max   = $signed(value);
      REG_OUT_MIN:   shadow_cfg.out_min   = $signed(value);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] gp, input logic [31:0] gi,
                             input logic [31:0] gd, input logic [31:0] st,
                             input logic [31:0] omax, input logic [31:0] omin);
    quiesce();
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_STEP_TIME, st);
    write_reg(REG_OUT_MAX, omax);
    write_reg(REG_OUT_MIN, omin);
  endtask

  // ------------------------------------------------------------------------
  // Random values
  // ------------------------------------------------------------------------

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 6))
      0:       return $urandom;
      1:       return WordMax;
      2:       return WordMin;
      3:       return '0;
      4:       return $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Bit 31 of a step time write is ignored by the block.
  function automatic logic [31:0] rand_step_time();
    case ($urandom_range(0, 6))
      0:       return $urandom;
      1:       return '0;
      2:       return WordMax;
      3:       return 32'd1;
      default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
    endcase
  endfunction

  task automatic load_random_config();
    logic [31:0] omax;
    logic [31:0] omin;
    case ($urandom_range(0, 5))
      0: begin
        omax = WordMax;
        omin = WordMin;
      end
      1: begin
        omax = 32'd0 - $urandom_range(0, 32'h0010_0000);
        omin = $urandom_range(0, 32'h0010_0000);
      end
      2: begin
        omax = $urandom;
        omin = $urandom;
      end
      default: begin
        omax = $urandom_range(0, 32'h0032_0000);
        omin = 32'd0 - $urandom_range(0, 32'h0032_0000);
      end
    endcase
    load_config(rand_gain(), rand_gain(), rand_gain(), rand_step_time(), omax, omin);
  endtask

  // Mostly a measurement tracking its setpoint, with some noise and extremes.
  task automatic send_random_step();
    logic [31:0] sp;
    logic [31:0] ms;
    logic [31:0] corners [4];
    corners = '{WordMax, WordMin, 32'd0, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0, 1: begin
        sp = $urandom;
        ms = $urandom;
      end
      2: begin
        sp = corners[$urandom_range(0, 3)];
        ms = corners[$urandom_range(0, 3)];
      end
      default: begin
        sp = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
        ms = sp + ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      end
    endcase
    send_step(sp, ms, $urandom_range(0, 15) == 0);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Register defaults after reset: unity P gain and full-range clamps.
  task automatic test_reset_defaults();
    send_step(32'd0, 32'd0, 1'b0);
    send_step(WordMax, WordMin, 1'b0);
    send_step(WordMin, WordMax, 1'b1);
    send_step(32'h0003_8000, 32'h0001_4000, 1'b0);
    send_step(32'hFFFF_FFFF, 32'd1, 1'b1);
  endtask

  // The I term is capped at 5.0 from above and left alone below.
  task automatic test_i_term_clamp();
    load_config(32'd0, QOne, 32'd0, QOne, WordMax, WordMin);
    send_step(32'h000A_0000, 32'd0, 1'b1);
    send_step(32'h0002_0000, 32'd0, 1'b0);
    send_step(32'd0, 32'h0014_0000, 1'b0);
    send_step(32'd0, 32'h0003_0000, 1'b0);
    send_step(32'h0001_0000, 32'd0, 1'b1);
  endtask

  // A zero time step acts as one LSB in the integral and the divide.
  task automatic test_zero_step_time();
    load_config(32'd0, QOne, QOne, 32'd0, WordMax, WordMin);
    send_step(32'h0001_0000, 32'd0, 1'b1);
    send_step(32'd0, 32'd0, 1'b0);
    send_step(WordMax, WordMin, 1'b0);
  endtask

  // Crossed clamps: above out_max wins, else below out_min.
  task automatic test_crossed_clamps();
    load_config(QOne, 32'd0, 32'd0, QOne, 32'hFFFF_0000, QOne);
    send_step(32'd0, 32'd0, 1'b0);
    send_step(32'd0, 32'h0002_0000, 1'b0);
    send_step(32'h0003_0000, 32'd0, 1'b0);
    quiesce();
    write_reg(REG_OUT_MIN, 32'hFFFF_0000);
    send_step(32'h0000_8000, 32'd0, 1'b0);
  endtask

  // Products, the integral and the quotient driven into saturation.
  task automatic test_saturation();
    load_config(WordMax, WordMin, WordMax, 32'd1, WordMax, WordMin);
    send_step(WordMax, WordMin, 1'b1);
    send_step(WordMin, WordMax, 1'b0);
    send_step(32'd1, 32'd0, 1'b0);
    load_config(32'd0, WordMax, WordMin, WordMax, WordMax, WordMin);
    send_step(WordMax, WordMin, 1'b1);
    send_step(WordMax, WordMin, 1'b0);
    send_step(WordMin, WordMax, 1'b0);
  endtask

  // Random phases, each with its own settings and idling mix.
  task automatic test_random_phases(input int phases, input int steps);
    for (int ph = 0; ph < phases; ph++) begin
      load_random_config();
      tx_idle_en = (ph % 4 == 0) || (ph % 4 == 1);
      rx_idle_en = (ph % 4 == 0) || (ph % 4 == 2);
      for (int n = 0; n < steps; n++) begin
        send_random_step();
        if ($urandom_range(0, 49) == 0) quiesce();
      end
    end
  endtask

  // The sender waits for every result before each new step.
  task automatic test_pressure(input int steps);
    load_random_config();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int n = 0; n < steps; n++) begin
      send_random_step();
      quiesce();
    end
  endtask

  // Back-to-back steps with no idling on either side.
  task automatic test_steady_stream(input int steps);
    load_random_config();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int n = 0; n < steps; n++) send_random_step();
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_i_term_clamp();
    test_zero_step_time();
    test_crossed_clamps();
    test_saturation();
    test_random_phases(8, 200);
    test_pressure(60);
    test_steady_stream(200);

    quiesce();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && drive_expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
